[rtl/rvd_pkg.sv]
package rvd_pkg;

  typedef struct packed {
    logic [63:0] raw_bytes;
    logic [3:0]  byte_count;
    logic [3:0]  data_type;
    logic        byte_little;
    logic        word_little;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [63:0] value;
  } out_item_t;

  localparam logic [3:0] DT_BOOL = 4'd0;
  localparam logic [3:0] DT_U8   = 4'd1;
  localparam logic [3:0] DT_I8   = 4'd2;
  localparam logic [3:0] DT_U16  = 4'd3;
  localparam logic [3:0] DT_I16  = 4'd4;
  localparam logic [3:0] DT_U32  = 4'd5;
  localparam logic [3:0] DT_I32  = 4'd6;
  localparam logic [3:0] DT_U64  = 4'd7;
  localparam logic [3:0] DT_I64  = 4'd8;
  localparam logic [3:0] DT_F32  = 4'd9;
  localparam logic [3:0] DT_F64  = 4'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [1:0] ST_LEN      = 2'd3;

  localparam logic [1:0] KIND_BOOL   = 2'd0;
  localparam logic [1:0] KIND_NUM    = 2'd1;
  localparam logic [1:0] KIND_BIG_U  = 2'd2;
  localparam logic [1:0] KIND_BIG_S  = 2'd3;

  localparam logic [63:0] SAFE_INT_MAX = 64'h001F_FFFF_FFFF_FFFF;

  // conversion classes handed from the front stage to the converter
  typedef enum logic [2:0] {
    CV_RAW  = 3'd0,
    CV_INT  = 3'd1,
    CV_F32  = 3'd2,
    CV_BIG  = 3'd3,
    CV_FIX  = 3'd4
  } conv_t;

  // stage 1 result: aligned integer magnitude and what to do with it
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    conv_t       conv;
    logic        neg;
    logic [63:0] word;
  } norm_t;

endpackage

[rtl/rvd_front.sv]
// byte ordering, extension, error checks and integer magnitude
module rvd_front (
  input  rvd_pkg::in_item_t item,
  output rvd_pkg::norm_t    norm
);

  logic [7:0]  buf_b [8];
  logic [7:0]  ord_b [8];
  logic [3:0]  want;
  logic [63:0] u;
  logic [63:0] mag;
  logic        any_nz;
  logic [3:0]  words;
  logic [3:0]  cnt;

  always_comb begin
    for (int i = 0; i < 8; i++) buf_b[i] = item.raw_bytes[8*i +: 8];

    case (item.data_type)
      rvd_pkg::DT_U8, rvd_pkg::DT_I8:                     want = 4'd1;
      rvd_pkg::DT_U16, rvd_pkg::DT_I16:                   want = 4'd2;
      rvd_pkg::DT_U32, rvd_pkg::DT_I32, rvd_pkg::DT_F32:  want = 4'd4;
      rvd_pkg::DT_U64, rvd_pkg::DT_I64, rvd_pkg::DT_F64:  want = 4'd8;
      default:                                            want = 4'd0;
    endcase
    words = want >> 1;

    // word reversal, then byte swap inside each word
    for (int i = 0; i < 8; i++) ord_b[i] = buf_b[i];
    if (item.word_little) begin
      for (int i = 0; i < 4; i++) begin
        if (4'(i) < words) begin
          ord_b[2*i]   = buf_b[2*(words - 4'(i) - 4'd1)];
          ord_b[2*i+1] = buf_b[2*(words - 4'(i) - 4'd1) + 1];
        end
      end
    end
    if (item.byte_little) begin
      for (int i = 0; i < 4; i++) begin
        if (4'(i) < words) begin
          {ord_b[2*i], ord_b[2*i+1]} = {ord_b[2*i+1], ord_b[2*i]};
        end
      end
    end

    // big-endian assembly of the wanted bytes
    case (want)
      4'd1:    u = {56'd0, ord_b[0]};
      4'd2:    u = {48'd0, ord_b[0], ord_b[1]};
      4'd4:    u = {32'd0, ord_b[0], ord_b[1], ord_b[2], ord_b[3]};
      default: u = {ord_b[0], ord_b[1], ord_b[2], ord_b[3],
                    ord_b[4], ord_b[5], ord_b[6], ord_b[7]};
    endcase

    // bool: any counted byte non-zero
    cnt = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
    any_nz = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt && buf_b[i] != 8'd0) any_nz = 1'b1;
    end

    norm = '0;
    norm.conv = rvd_pkg::CV_FIX;
    mag = u;
    if (item.data_type == rvd_pkg::DT_BOOL) begin
      if (item.byte_count == 4'd0) norm.status = rvd_pkg::ST_EMPTY;
      else norm.word = {63'd0, any_nz};
    end else if (want == 4'd0) begin
      norm.status = rvd_pkg::ST_BAD_TYPE;
    end else if (item.byte_count != want) begin
      norm.status = rvd_pkg::ST_LEN;
    end else begin
      norm.kind = rvd_pkg::KIND_NUM;
      // negation at the type's own width, then zero extension
      case (item.data_type)
        rvd_pkg::DT_I8: begin
          norm.neg = u[7];
          mag = u[7] ? {56'd0, 8'(~u[7:0] + 8'd1)} : u;
        end
        rvd_pkg::DT_I16: begin
          norm.neg = u[15];
          mag = u[15] ? {48'd0, 16'(~u[15:0] + 16'd1)} : u;
        end
        rvd_pkg::DT_I32: begin
          norm.neg = u[31];
          mag = u[31] ? {32'd0, 32'(~u[31:0] + 32'd1)} : u;
        end
        rvd_pkg::DT_I64: begin norm.neg = u[63]; mag = u[63] ? ~u + 64'd1 : u; end
        default:         mag = u;
      endcase
      case (item.data_type)
        rvd_pkg::DT_F32: begin norm.conv = rvd_pkg::CV_F32; norm.word = u; end
        rvd_pkg::DT_F64: begin norm.conv = rvd_pkg::CV_RAW; norm.word = u; end
        rvd_pkg::DT_U64: begin
          if (u > rvd_pkg::SAFE_INT_MAX) begin
            norm.conv = rvd_pkg::CV_BIG; norm.kind = rvd_pkg::KIND_BIG_U; norm.word = u;
          end else begin
            norm.conv = rvd_pkg::CV_INT; norm.word = u;
          end
        end
        rvd_pkg::DT_I64: begin
          if (mag > rvd_pkg::SAFE_INT_MAX) begin
            norm.conv = rvd_pkg::CV_BIG; norm.kind = rvd_pkg::KIND_BIG_S; norm.word = u;
          end else begin
            norm.conv = rvd_pkg::CV_INT; norm.word = mag;
          end
        end
        default: begin norm.conv = rvd_pkg::CV_INT; norm.word = mag; end
      endcase
    end
  end

endmodule

[rtl/rvd_lzc.sv]
// leading zero count of a 64-bit word, 7-bit result (64 when zero)
module rvd_lzc (
  input  logic [63:0] word,
  output logic [6:0]  lz
);

  logic [3:0] nib_lz [8];
  logic [7:0] nib_nz;

  // per-byte count, then first non-zero byte from the top
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      nib_nz[b] = |word[8*b +: 8];
      nib_lz[b] = 4'd8;
      for (int k = 0; k < 8; k++) begin
        if (word[8*b + k]) nib_lz[b] = 4'(7 - k);
      end
    end
    lz = 7'd64;
    for (int b = 0; b < 8; b++) begin
      if (nib_nz[b]) lz = 7'(8 * (7 - b)) + 7'(nib_lz[b]);
    end
  end

endmodule

[rtl/register_value_decoder_top.sv]
// register value decoder
// in_ channel: raise start with in_item for one cycle; busy is never high,
// so an item may be presented in every clock cycle.
// out_ channel: out_valid strobes for one cycle with out_item (status, kind,
// value); the receiver takes it on that edge and cannot hold it off.
// path: an item passes through four stages: byte ordering and integer
// magnitude, leading zero count, normalising shift, exponent and output
// register.
// throughput: one item per clock, fixed by the pipeline having no feedback.
// f32 widening shares the count and shift for subnormals.
// errors give kind 0 and value 0 with a non-zero status.
// reset: rst_n low at a clock edge clears all valid bits; items in flight
// are dropped and no strobe follows until new items enter.
// the block holds no state between items.
module register_value_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rvd_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rvd_pkg::out_item_t out_item
);

  rvd_pkg::norm_t norm, s1_r, s2_r;
  logic           v1_r, v2_r, v3_r;
  logic [6:0]     lz, s2_lz_r;
  logic [63:0]    s3_shl_r;
  logic [6:0]     s3_lz_r;
  rvd_pkg::norm_t s3_r;
  logic [22:0]    f_in;

  assign busy = 1'b0;

  rvd_front u_front (.item(in_item), .norm(norm));

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    s1_r <= norm;
  end

  // count leading zeros of an integer or of an f32 subnormal fraction
  logic [63:0] lz_in;
  always_comb begin
    if (s1_r.conv == rvd_pkg::CV_F32) lz_in = {s1_r.word[22:0], 41'd0};
    else lz_in = s1_r.word;
  end
  rvd_lzc u_lzc (.word(lz_in), .lz(lz));

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    s2_r    <= s1_r;
    s2_lz_r <= lz;
  end

  // normalising shift
  always_comb f_in = s2_r.word[22:0];
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    s3_r    <= s2_r;
    s3_lz_r <= s2_lz_r;
    if (s2_r.conv == rvd_pkg::CV_F32) s3_shl_r <= {f_in, 41'd0} << s2_lz_r[5:0];
    else s3_shl_r <= s2_r.word << s2_lz_r[5:0];
  end

  // exponent assembly and output register
  logic [63:0] val;
  logic [10:0] iexp, fexp;
  logic [7:0]  e8;
  always_comb begin
    iexp = 11'(1023 + 63) - 11'(s3_lz_r);
    e8   = s3_r.word[30:23];
    fexp = 11'(896) - 11'(s3_lz_r);
    val  = '0;
    case (s3_r.conv)
      rvd_pkg::CV_INT: begin
        if (s3_r.word == 64'd0) val = '0;
        else val = {s3_r.neg, iexp, s3_shl_r[62:11]};
      end
      rvd_pkg::CV_F32: begin
        if (e8 == 8'hFF)
          val = {s3_r.word[31], 11'h7FF, s3_r.word[22:0], 29'd0}
                | {12'd0, (s3_r.word[22:0] != 23'd0), 51'd0};
        else if (e8 != 8'd0)
          val = {s3_r.word[31], 11'(e8) + 11'd896, s3_r.word[22:0], 29'd0};
        else if (s3_r.word[22:0] == 23'd0)
          val = {s3_r.word[31], 63'd0};
        else
          val = {s3_r.word[31], fexp, s3_shl_r[62:11]};
      end
      rvd_pkg::CV_RAW, rvd_pkg::CV_BIG, rvd_pkg::CV_FIX: val = s3_r.word;
      default: val = s3_r.word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v3_r;
    out_item.status <= s3_r.status;
    out_item.kind   <= s3_r.kind;
    out_item.value  <= val;
  end

endmodule
